### hw/rtl/meti_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
package meti_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int SIZE_BITS      = 13;
    localparam int COORD_BITS     = 12;
    localparam int ITER_BITS      = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER     = 2'd2;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET    = 13'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET   = 13'd600;
    localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = 24'd524288;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_DIV_SX,
        OP_DIV_SY,
        OP_MAP_RE,
        OP_MAP_IM,
        OP_SQ_IM,
        OP_DISK0,
        OP_DISK1,
        OP_SQ_AR,
        OP_SQ_AI,
        OP_SQRT,
        OP_DIV_Q,
        OP_CARD,
        OP_ZR2,
        OP_ZI2,
        OP_CROSS
    } meti_op_t;

    typedef struct packed {
        logic     start;
        meti_op_t op;
        logic     load;
        logic     out_load;
    } meti_cmd_t;

    typedef struct packed {
        logic done;
        logic in_set;
        logic in_range;
        logic n_zero;
        logic escape;
    } meti_sts_t;

endpackage

### hw/rtl/meti_mul.sv
// Unsigned multiplier built from four half-width partial products, formed and accumulated in turn.
module meti_mul #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);
    localparam int H  = (W + 1) / 2;
    localparam int AW = 2 * H;
    localparam int PW = 4 * H;

    logic [AW-1:0] a_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] pp_reg;
    logic [1:0]    sh_reg;
    logic [PW-1:0] acc_reg;
    logic [2:0]    ph_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [H-1:0]  al, ah, bl, bh;
    logic [PW-1:0] pp_shifted;

    assign al = a_reg[H-1:0];
    assign ah = a_reg[AW-1:H];
    assign bl = b_reg[H-1:0];
    assign bh = b_reg[AW-1:H];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = PW'(pp_reg);
            2'd1:    pp_shifted = PW'(pp_reg) << H;
            default: pp_shifted = PW'(pp_reg) << AW;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= AW'(a);
            b_reg   <= AW'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            case (ph_reg)
                3'd0:
                begin
                    pp_reg <= al * bl;
                    sh_reg <= 2'd0;
                end
                3'd1:
                begin
                    pp_reg <= al * bh;
                    sh_reg <= 2'd1;
                end
                3'd2:
                begin
                    pp_reg <= ah * bl;
                    sh_reg <= 2'd1;
                end
                default:
                begin
                    pp_reg <= ah * bh;
                    sh_reg <= 2'd2;
                end
            endcase
            if (ph_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[2*W-1:0];

endmodule

### hw/rtl/meti_div.sv
// Restoring long divider, one quotient bit per cycle, numerator taken MSB first.
module meti_div #(
    parameter int NW = 56,
    parameter int DW = 32,
    parameter int QW = 30,
    parameter int CW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [CW-1:0] steps,
    output logic          done,
    output logic [QW-1:0] quo
);
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] r_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   rs;
    logic [DW:0]   rd;
    logic          take;

    always_comb
    begin
        rs   = {r_reg, num_reg[NW-1]};
        take = (rs >= {1'b0, den_reg});
        rd   = rs - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            r_reg   <= take ? rd[DW-1:0] : rs[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### hw/rtl/meti_sqrt.sv
// Integer square root, one root bit per cycle.
module meti_sqrt #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2*W-1:0] rad,
    output logic           done,
    output logic [W-1:0]   root
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] rad_reg;
    logic [W+1:0]   rem_reg;
    logic [W-1:0]   root_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [W+3:0]   rs;
    logic [W+3:0]   trial;
    logic [W+3:0]   diff;
    logic           take;

    always_comb
    begin
        rs    = {rem_reg, rad_reg[2*W-1:2*W-2]};
        trial = {2'b00, root_reg, 2'b01};
        take  = (rs >= trial);
        diff  = rs - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? diff[W+1:0] : rs[W+1:0];
            root_reg <= {root_reg[W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hw/rtl/meti_dp.sv
// Datapath: coordinate mapping, set-membership tests and the z = z*z + c loop.
module meti_dp #(
    parameter int F  = 28,
    parameter int CB = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  meti_pkg::meti_cmd_t                 cmd,
    input  logic [meti_pkg::COORD_BITS-1:0]     column,
    input  logic [meti_pkg::COORD_BITS-1:0]     row,
    input  logic [meti_pkg::SIZE_BITS-1:0]      image_width,
    input  logic [meti_pkg::SIZE_BITS-1:0]      image_height,
    input  logic [meti_pkg::ITER_BITS-1:0]      max_iter,
    output meti_pkg::meti_sts_t                 sts,
    output logic [meti_pkg::ITER_BITS-1:0]      iteration_count
);
    import meti_pkg::*;

    localparam int W  = F + 4;
    localparam int NW = 2 * F;
    localparam int QW = F + 2;
    localparam int CW = $clog2(NW + 1);

    localparam logic signed [W-1:0] FX_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] FX_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] FX_ONE  = W'(1) << F;
    localparam logic signed [W-1:0] QSQ     = W'(1) << (F - 4);
    localparam logic signed [W-1:0] FOUR    = W'(1) << (F + 2);
    localparam logic signed [W-1:0] QUARTER = W'(1) << (F - 2);
    localparam logic signed [W-1:0] HALF    = W'(1) << (F - 1);
    localparam logic signed [W-1:0] NEG_3Q  = -(W'(3) << (F - 2));
    localparam logic [W-1:0]        BASE_X  = -(W'(2) << F);
    localparam logic [W-1:0]        BASE_Y  = -(W'(9) << (F - 3));
    localparam logic [2*W-1:0]      LIM_X   = (2*W)'(FX_MAX) + ((2*W)'(1) << (F + 1));
    localparam logic [2*W-1:0]      LIM_Y   = (2*W)'(FX_MAX) + ((2*W)'(9) << (F - 3));
    localparam logic [32:0]         CAP     = (33'(1) << CB) - 33'(1);

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1])
            sadd = s[W] ? FX_MIN : FX_MAX;
        else
            sadd = s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        if (s[W] != s[W-1])
            ssub = s[W] ? FX_MIN : FX_MAX;
        else
            ssub = s[W-1:0];
    endfunction

    // floor(+/- p / 2^F), the sign applied before rounding down, saturated
    function automatic logic signed [W-1:0] fmul_fix(input logic [2*W-1:0] p,
                                                     input logic neg);
        logic [W+3:0] q;
        logic [W+4:0] qn;
        q  = p[2*W-1:F];
        qn = (W+5)'(q) + (W+5)'(|p[F-1:0]);
        if (!neg)
            fmul_fix = (q > (W+4)'(FX_MAX)) ? FX_MAX : q[W-1:0];
        else if (qn > (W+5)'(FX_MAX) + (W+5)'(1))
            fmul_fix = FX_MIN;
        else
            fmul_fix = W'(0) - qn[W-1:0];
    endfunction

    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [CB-1:0]         limit_reg, count_reg;
    logic [QW-1:0]         stx_reg, sty_reg, uq_reg;
    logic signed [W-1:0]   re_reg, im_reg, im2_reg, zr_reg, zi_reg, zr2_reg, zi2_reg;
    logic [2*W-1:0]        s_reg;
    logic [W-1:0]          n_reg;
    logic [ITER_BITS-1:0]  res_reg;
    meti_op_t              op_reg;
    logic                  done_reg;
    logic                  inside_reg;

    logic [W-1:0]     mul_a, mul_b;
    logic             mul_go, div_go, sqrt_go;
    logic             mul_done, div_done, sqrt_done;
    logic [2*W-1:0]   mul_prod;
    logic [NW-1:0]    div_num;
    logic [W-1:0]     div_den;
    logic [CW-1:0]    div_steps;
    logic [QW-1:0]    div_quo;
    logic [W-1:0]     sqrt_root;

    logic [SIZE_BITS-1:0] wm1, hm1;
    logic signed [W-1:0]  re1, tr, fm, sum2;
    logic [W-1:0]         ar;
    logic                 cross_neg;
    logic                 card_in;
    logic signed [W+2:0]  uqe, qs, one_e, half_v, ne;
    logic [32:0]          lim33;
    logic [31:0]          cnt32, lim32;

    always_comb
    begin
        wm1       = (image_width < SIZE_BITS'(2)) ? SIZE_BITS'(1) : image_width - 1'b1;
        hm1       = (image_height < SIZE_BITS'(2)) ? SIZE_BITS'(1) : image_height - 1'b1;
        lim33     = (33'(max_iter) > CAP) ? CAP : 33'(max_iter);
        re1       = sadd(re_reg, FX_ONE);
        tr        = re_reg - QUARTER;
        ar        = mag(tr);
        cross_neg = zr_reg[W-1] ^ zi_reg[W-1];
        fm        = fmul_fix(mul_prod, (op_reg == OP_CROSS) && cross_neg);
        sum2      = sadd(zr2_reg, zi2_reg);
        // cardioid: inside when n < floor((1 - q) / 2), q = +/- ar / n
        uqe       = $signed((W+3)'(uq_reg));
        qs        = tr[W-1] ? -uqe : uqe;
        one_e     = $signed((W+3)'(FX_ONE));
        half_v    = (one_e - qs) >>> 1;
        ne        = $signed((W+3)'(n_reg));
        card_in   = (n_reg != '0) && (ne < half_v);
        cnt32     = 32'(count_reg);
        lim32     = 32'(limit_reg);
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_go    = 1'b0;
        div_go    = 1'b0;
        sqrt_go   = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        case (cmd.op)
            OP_DIV_SX:
            begin
                div_go    = 1'b1;
                div_num   = NW'(3) << (NW - 2);
                div_den   = W'(wm1);
                div_steps = CW'(F + 2);
            end
            OP_DIV_SY:
            begin
                div_go    = 1'b1;
                div_num   = NW'(9) << (NW - 4);
                div_den   = W'(hm1);
                div_steps = CW'(F + 2);
            end
            OP_DIV_Q:
            begin
                div_go    = 1'b1;
                div_num   = {ar[F-1:0], {F{1'b0}}};
                div_den   = n_reg;
                div_steps = CW'(NW);
            end
            OP_MAP_RE:
            begin
                mul_go = 1'b1;
                mul_a  = W'(col_reg);
                mul_b  = W'(stx_reg);
            end
            OP_MAP_IM:
            begin
                mul_go = 1'b1;
                mul_a  = W'(row_reg);
                mul_b  = W'(sty_reg);
            end
            OP_SQ_IM, OP_SQ_AI:
            begin
                mul_go = 1'b1;
                mul_a  = mag(im_reg);
                mul_b  = mag(im_reg);
            end
            OP_DISK0:
            begin
                mul_go = 1'b1;
                mul_a  = mag(re_reg);
                mul_b  = mag(re_reg);
            end
            OP_DISK1:
            begin
                mul_go = 1'b1;
                mul_a  = mag(re1);
                mul_b  = mag(re1);
            end
            OP_SQ_AR:
            begin
                mul_go = 1'b1;
                mul_a  = ar;
                mul_b  = ar;
            end
            OP_SQRT:
            begin
                sqrt_go = 1'b1;
            end
            OP_ZR2:
            begin
                mul_go = 1'b1;
                mul_a  = mag(zr_reg);
                mul_b  = mag(zr_reg);
            end
            OP_ZI2:
            begin
                mul_go = 1'b1;
                mul_a  = mag(zi_reg);
                mul_b  = mag(zi_reg);
            end
            OP_CROSS:
            begin
                mul_go = 1'b1;
                mul_a  = mag(zr_reg);
                mul_b  = mag(zi_reg);
            end
            default:
            begin
                mul_go = 1'b0;
            end
        endcase
    end

    meti_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start && mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    meti_div #(.NW(NW), .DW(W), .QW(QW), .CW(CW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start && div_go),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .done  (div_done),
        .quo   (div_quo)
    );

    meti_sqrt #(.W(W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start && sqrt_go),
        .rad   (s_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_NONE;
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mul_done || div_done || sqrt_done ||
                        (cmd.start && (cmd.op == OP_CARD));
            if (cmd.start)
            begin
                op_reg <= cmd.op;
            end
            if (cmd.load)
            begin
                inside_reg <= 1'b0;
            end
            else if (mul_done && ((op_reg == OP_DISK0) || (op_reg == OP_DISK1)))
            begin
                inside_reg <= inside_reg || (sadd(fm, im2_reg) < QSQ);
            end
            else if (cmd.start && (cmd.op == OP_CARD))
            begin
                inside_reg <= inside_reg || card_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg   <= column;
            row_reg   <= row;
            limit_reg <= lim33[CB-1:0];
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        if (div_done)
        begin
            case (op_reg)
                OP_DIV_SX: stx_reg <= div_quo;
                OP_DIV_SY: sty_reg <= div_quo;
                default:   uq_reg  <= div_quo;
            endcase
        end
        if (sqrt_done)
        begin
            n_reg <= sqrt_root;
        end
        if (mul_done)
        begin
            case (op_reg)
                OP_MAP_RE: re_reg  <= (mul_prod > LIM_X) ? FX_MAX : (mul_prod[W-1:0] + BASE_X);
                OP_MAP_IM: im_reg  <= (mul_prod > LIM_Y) ? FX_MAX : (mul_prod[W-1:0] + BASE_Y);
                OP_SQ_IM:  im2_reg <= fm;
                OP_SQ_AR:  s_reg   <= mul_prod;
                OP_SQ_AI:  s_reg   <= s_reg + mul_prod;
                OP_ZR2:    zr2_reg <= fm;
                OP_ZI2:    zi2_reg <= fm;
                OP_CROSS:
                begin
                    zr_reg    <= sadd(ssub(zr2_reg, zi2_reg), re_reg);
                    zi_reg    <= sadd(sadd(fm, fm), im_reg);
                    count_reg <= count_reg + 1'b1;
                end
                default:
                begin
                    s_reg <= s_reg;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            res_reg <= inside_reg ? lim32[ITER_BITS-1:0] : cnt32[ITER_BITS-1:0];
        end
    end

    assign sts.done     = done_reg;
    assign sts.in_set   = inside_reg;
    assign sts.in_range = (re_reg > NEG_3Q) && (re_reg < HALF);
    assign sts.n_zero   = (n_reg == '0);
    assign sts.escape   = (sum2 >= FOUR) || (count_reg >= limit_reg);

    assign iteration_count = res_reg;

endmodule

### hw/rtl/meti_ctrl.sv
// Controller: sequences datapath operations for one pixel and runs both handshakes.
module meti_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                size_write,
    input  meti_pkg::meti_sts_t sts,
    output meti_pkg::meti_cmd_t cmd
);
    import meti_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_SX,
        S_DIV_SY,
        S_MAP_RE,
        S_MAP_IM,
        S_SQ_IM,
        S_DISK0,
        S_DISK1,
        S_SQ_AR,
        S_SQ_AI,
        S_SQRT,
        S_DIV_Q,
        S_CARD,
        S_ZR2,
        S_ZI2,
        S_CROSS,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   issue_reg;
    logic   stale_reg;
    logic   out_valid_reg;
    logic   in_fire;
    logic   out_load;
    meti_op_t op;

    always_comb
    begin
        case (state_reg)
            S_DIV_SX: op = OP_DIV_SX;
            S_DIV_SY: op = OP_DIV_SY;
            S_MAP_RE: op = OP_MAP_RE;
            S_MAP_IM: op = OP_MAP_IM;
            S_SQ_IM:  op = OP_SQ_IM;
            S_DISK0:  op = OP_DISK0;
            S_DISK1:  op = OP_DISK1;
            S_SQ_AR:  op = OP_SQ_AR;
            S_SQ_AI:  op = OP_SQ_AI;
            S_SQRT:   op = OP_SQRT;
            S_DIV_Q:  op = OP_DIV_Q;
            S_CARD:   op = OP_CARD;
            S_ZR2:    op = OP_ZR2;
            S_ZI2:    op = OP_ZI2;
            S_CROSS:  op = OP_CROSS;
            default:  op = OP_NONE;
        endcase
    end

    assign in_fire  = in_valid && (state_reg == S_IDLE);
    // result register frees up in the same cycle its transaction completes
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            issue_reg <= 1'b0;
            if (size_write)
            begin
                stale_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= stale_reg ? S_DIV_SX : S_MAP_RE;
                        issue_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    if (sts.done)
                    begin
                        issue_reg <= 1'b1;
                        case (state_reg)
                            S_DIV_SX: state_reg <= S_DIV_SY;
                            S_DIV_SY:
                            begin
                                state_reg <= S_MAP_RE;
                                stale_reg <= 1'b0;
                            end
                            S_MAP_RE: state_reg <= S_MAP_IM;
                            S_MAP_IM: state_reg <= S_SQ_IM;
                            S_SQ_IM:  state_reg <= S_DISK0;
                            S_DISK0:  state_reg <= S_DISK1;
                            S_DISK1:
                            begin
                                if (sts.in_set)
                                begin
                                    state_reg <= S_DONE;
                                    issue_reg <= 1'b0;
                                end
                                else if (sts.in_range)
                                    state_reg <= S_SQ_AR;
                                else
                                    state_reg <= S_ZR2;
                            end
                            S_SQ_AR:  state_reg <= S_SQ_AI;
                            S_SQ_AI:  state_reg <= S_SQRT;
                            S_SQRT:   state_reg <= sts.n_zero ? S_ZR2 : S_DIV_Q;
                            S_DIV_Q:  state_reg <= S_CARD;
                            S_CARD:
                            begin
                                if (sts.in_set)
                                begin
                                    state_reg <= S_DONE;
                                    issue_reg <= 1'b0;
                                end
                                else
                                    state_reg <= S_ZR2;
                            end
                            S_ZR2:    state_reg <= S_ZI2;
                            S_ZI2:
                            begin
                                if (sts.escape)
                                begin
                                    state_reg <= S_DONE;
                                    issue_reg <= 1'b0;
                                end
                                else
                                    state_reg <= S_CROSS;
                            end
                            default:  state_reg <= S_ZR2;
                        endcase
                    end
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign cmd.start    = issue_reg;
    assign cmd.op       = op;
    assign cmd.load     = in_fire;
    assign cmd.out_load = out_load;

endmodule

### hw/rtl/mandelbrot_escape_time_pixel.sv
// Top level: configuration registers, controller and datapath of the escape-time pixel.
//
// Usage: each input transaction (column, row) names one pixel; exactly one output
// transaction (iteration_count) follows, in order. Both channels use valid/stall; a
// transaction completes on a clock edge with valid high and stall low.
// image_width, image_height and max_iter are written through cfg_write/cfg_index/
// cfg_data while the block is idle; they reset to 800, 600 and 524288.
// Sequencing: one pixel at a time. Every multiply runs on the shared four-partial-product
// multiplier. Mapping and the two disk tests cost 5 multiplies. The first pixel after
// reset or a size write also runs two step divisions. Points in the cardioid window add
// two multiplies, a square root, and a divide and a decision step unless the root is zero.
// Each iteration of z = z*z + c takes three multiplies and the final escape check two more.
// A finished result sits in an output register; the next pixel is accepted while it
// waits, and the block holds in its done state if the receiver still stalls then.
// Reset (rst_n low, asynchronous) clears all control state and drops both handshakes.
module mandelbrot_escape_time_pixel #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [meti_pkg::COORD_BITS-1:0]      column,
    input  logic [meti_pkg::COORD_BITS-1:0]      row,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [meti_pkg::ITER_BITS-1:0]       iteration_count,
    input  logic                                 cfg_write,
    input  logic [meti_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [meti_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import meti_pkg::*;

    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;
    logic [ITER_BITS-1:0] max_iter_reg;
    logic                 size_write;
    meti_cmd_t            cmd;
    meti_sts_t            sts;

    assign size_write = cfg_write &&
                        ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg    <= cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg   <= cfg_data[SIZE_BITS-1:0];
                CFG_MAX_ITER:     max_iter_reg <= cfg_data[ITER_BITS-1:0];
                default:          width_reg    <= width_reg;
            endcase
        end
    end

    meti_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .size_write (size_write),
        .sts        (sts),
        .cmd        (cmd)
    );

    meti_dp #(.F(FRAC_BITS), .CB(COUNT_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .column          (column),
        .row             (row),
        .image_width     (width_reg),
        .image_height    (height_reg),
        .max_iter        (max_iter_reg),
        .sts             (sts),
        .iteration_count (iteration_count)
    );

endmodule

### tb/mandelbrot_escape_time_pixel_checker.sv
// Checker for the escape-time pixel block: tracks configuration, predicts counts, compares.
module mandelbrot_escape_time_pixel_checker
    import meti_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [COORD_BITS-1:0]     column,
    input  logic [COORD_BITS-1:0]     row,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [ITER_BITS-1:0]      iteration_count,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        pending,
    output int                        failures
);

    localparam int    FRAC   = 28;
    localparam longint ONE   = longint'(1) << FRAC;
    localparam longint FXMAX = (longint'(1) << (FRAC + 3)) - 1;
    localparam longint FXMIN = -FXMAX - 1;

    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;
    logic [ITER_BITS-1:0] iter_limit;
    logic [ITER_BITS-1:0] count_queue[$];

    function automatic longint clamp(longint x);
        if (x > FXMAX)
            return FXMAX;
        if (x < FXMIN)
            return FXMIN;
        return x;
    endfunction

    // floor of the scaled product, then saturate
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp(p >>> FRAC);
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic bit in_main_cardioid(longint re, longint im);
        longint       tr;
        logic [127:0] ar;
        logic [127:0] ai;
        logic [63:0]  n;
        logic [127:0] uq;
        longint       q;
        tr = re - ONE / 4;
        ar = (tr < 0) ? -tr : tr;
        ai = (im < 0) ? -im : im;
        n = isqrt(ar * ar + ai * ai);
        if (n == 0)
            return 1'b0;   // cusp
        uq = (ar << FRAC) / {64'd0, n};
        q = (tr < 0) ? -longint'(uq) : longint'(uq);
        return longint'(n) < ((ONE - q) >>> 1);
    endfunction

    function automatic logic [ITER_BITS-1:0] escape_count(logic [COORD_BITS-1:0] col,
                                                          logic [COORD_BITS-1:0] rw);
        longint w;
        longint h;
        longint re;
        longint im;
        longint im2;
        longint zr;
        longint zi;
        longint zr2;
        longint zi2;
        longint zrzi;
        longint count;
        longint limit;
        w = (width_reg < 2) ? 2 : longint'(width_reg);
        h = (height_reg < 2) ? 2 : longint'(height_reg);
        re = clamp(-2 * ONE + longint'(col) * ((3 * ONE) / (w - 1)));
        im = clamp(-((longint'(9) << FRAC) / 8) +
                   longint'(rw) * ((longint'(9) << FRAC) / 4 / (h - 1)));
        limit = longint'(iter_limit);
        im2 = fx_mul(im, im);
        if (clamp(fx_mul(re, re) + im2) < ONE / 16 ||
            clamp(fx_mul(clamp(re + ONE), clamp(re + ONE)) + im2) < ONE / 16 ||
            (re > -(3 * ONE / 4) && re < ONE / 2 && in_main_cardioid(re, im)))
            return limit[ITER_BITS-1:0];
        zr = 0;
        zi = 0;
        count = 0;
        forever
        begin
            zr2 = fx_mul(zr, zr);
            zi2 = fx_mul(zi, zi);
            if (clamp(zr2 + zi2) >= 4 * ONE || count >= limit)
                break;
            zrzi = fx_mul(zr, zi);
            zr = clamp(clamp(zr2 - zi2) + re);
            zi = clamp(clamp(zrzi + zrzi) + im);
            count++;
        end
        return count[ITER_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            iter_limit = MAX_ITER_RESET;
            count_queue.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_data[SIZE_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data[SIZE_BITS-1:0];
                    CFG_MAX_ITER:     iter_limit = cfg_data[ITER_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                count_queue.push_back(escape_count(column, row));
            if (out_valid && !out_stall)
            begin
                if (count_queue.size() == 0)
                begin
                    $error("unexpected transaction: iteration_count=%0d", iteration_count);
                    failures++;
                end
                else
                begin
                    logic [ITER_BITS-1:0] want;
                    want = count_queue.pop_front();
                    if (want !== iteration_count)
                    begin
                        $error("iteration_count: expected %0d, actual %0d", want,
                               iteration_count);
                        failures++;
                    end
                end
            end
            pending = count_queue.size();
        end
    end

endmodule

### tb/tb_mandelbrot_escape_time_pixel.sv
// Testbench top: stimulus, handshake idling and verdict for the escape-time pixel block.
module tb_mandelbrot_escape_time_pixel;
    import meti_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [COORD_BITS-1:0]     column = '0;
    logic [COORD_BITS-1:0]     row = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [ITER_BITS-1:0]      iteration_count;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    int                        pending;
    int                        failures;
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    int                        cur_width = 800;
    int                        cur_height = 600;

    always #4 clk = ~clk;

    mandelbrot_escape_time_pixel dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .column(column), .row(row),
        .out_valid(out_valid), .out_stall(out_stall), .iteration_count(iteration_count),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mandelbrot_escape_time_pixel_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .column(column), .row(row),
        .out_valid(out_valid), .out_stall(out_stall), .iteration_count(iteration_count),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .failures(failures)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic send_pixel(int c, int r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        column   <= c[COORD_BITS-1:0];
        row      <= r[COORD_BITS-1:0];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_image(int w, int h, int limit);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_MAX_ITER, limit);
        cur_width  = w;
        cur_height = h;
    endtask

    function automatic int pick_size();
        case ($urandom_range(5))
            0: return 2;
            1: return 3;
            2: return 8191;
            3: return $urandom_range(1);
            default: return $urandom_range(2, 4096);
        endcase
    endfunction

    function automatic int pick_coord(int extent);
        int top;
        top = (extent < 2) ? 1 : extent - 1;
        if (top > 4095)
            top = 4095;
        if ($urandom_range(4) == 0)
            return $urandom_range(4095);
        return $urandom_range(top);
    endfunction

    initial
    begin
        send_idle_pct = 30;
        recv_idle_pct = 69;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: only pixels that settle quickly
        send_pixel(533, 300);    // disk around 0
        send_pixel(266, 300);    // disk around -1
        send_pixel(400, 300);    // main cardioid
        send_pixel(4095, 0);     // saturated coordinate
        send_pixel(4095, 4095);

        // coarse grid hitting exact points, cusp at column 9 of row 1
        set_image(13, 3, 20);
        for (int c = 0; c < 13; c++)
            send_pixel(c, 1);
        send_pixel(0, 0);

        set_image(0, 1, 0);      // tiny sizes, zero limit
        send_pixel(0, 0);
        send_pixel(1, 1);
        set_image(1, 0, 1);
        send_pixel(2, 2);

        set_image(4096, 4096, 16777215);
        send_pixel(4095, 2048);
        send_pixel(2730, 2048);
        set_image(8191, 8191, 16777215);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 69 : 0;
            recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 30 : 0;
            for (int set = 0; set < 3; set++)
            begin
                set_image(pick_size(), pick_size(),
                          (set == 2 && mode == 2) ? 0 : $urandom_range(1, 48));
                for (int i = 0; i < 50; i++)
                    send_pixel(pick_coord(cur_width), pick_coord(cur_height));
            end
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### mandelbrot_escape_time_pixel.f
hw/rtl/meti_pkg.sv
hw/rtl/meti_mul.sv
hw/rtl/meti_div.sv
hw/rtl/meti_sqrt.sv
hw/rtl/meti_dp.sv
hw/rtl/meti_ctrl.sv
hw/rtl/mandelbrot_escape_time_pixel.sv
tb/mandelbrot_escape_time_pixel_checker.sv
tb/tb_mandelbrot_escape_time_pixel.sv
